@@ src/ebml_pkg.sv @@
// ----------------------------------------------------------------------------
// ebml_pkg
// Shared types and constants for the EBML element encoder.
// ----------------------------------------------------------------------------
package ebml_pkg;

    typedef enum logic [1:0] {
        CMD_UINT   = 2'd0,
        CMD_VINT   = 2'd1,
        CMD_MARKER = 2'd2,
        CMD_ID     = 2'd3
    } cmd_t;

    localparam logic [63:0] VINT_LIMIT  = 64'h00FF_FFFF_FFFF_FFFF;
    localparam logic [3:0]  MAX_LEN     = 4'd8;
    localparam logic [8:0]  MARKER_BASE = 9'h1ff;
    localparam logic [7:0]  UINT_HDR    = 8'h80;
    localparam logic [7:0]  ERR_BYTE    = 8'h00;

    // Byte plan for one command: ID bytes, optional header byte, value bytes.
    typedef struct packed {
        logic        err;
        logic [31:0] id;
        logic [2:0]  id_cnt;
        logic [7:0]  hdr;
        logic        hdr_cnt;
        logic [63:0] val;
        logic [3:0]  val_cnt;
        logic [3:0]  total;
    } desc_t;

endpackage

@@ src/ebml_element_encoder_top.sv @@
// ----------------------------------------------------------------------------
// ebml_element_encoder_top
// EBML element serializer: one command in, a stream of encoded bytes out.
//
// Input channel (in_valid/in_ready) takes one command per beat: cmd,
// element_id, value and length. Output channel (out_valid/out_ready)
// delivers one byte per beat, most significant first, with last on the
// final byte of each command and error on the single error byte.
// A command becomes a byte plan in the same cycle it is accepted and waits
// in a two-entry queue, from which the serializer walks the head plan.
// The first byte goes through the queue entry, then the registered output
// stage. Throughput: one output byte per cycle while out_ready holds; a
// command is 1 to 13 bytes, and commands follow each other with no gap.
// When the receiver stalls, the output byte holds and the queue fills;
// in_ready drops only while both queue entries are occupied.
// Reset clears the queue and output stage; no command is in flight after it.
// ----------------------------------------------------------------------------
module ebml_element_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] element_id,
    input  logic [63:0] value,
    input  logic [3:0]  length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic        error
);

    ebml_pkg::desc_t front_desc;
    ebml_pkg::desc_t head_desc;
    logic            q_full;
    logic            head_valid;
    logic            pop;

    ebml_front u_front (
        .cmd        (cmd),
        .element_id (element_id),
        .value      (value),
        .length     (length),
        .desc       (front_desc)
    );

    ebml_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid),
        .push_desc  (front_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    ebml_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

    assign in_ready = !q_full;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last)
    else $error("error byte without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> (out_byte == ebml_pkg::ERR_BYTE))
    else $error("error byte is not zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> head_valid)
    else $error("input stalled with empty queue");

endmodule

@@ src/ebml_front.sv @@
// ----------------------------------------------------------------------------
// ebml_front
// Classify one command into a byte plan: counts, header byte and error flag.
// ----------------------------------------------------------------------------
module ebml_front (
    input  logic [1:0]     cmd,
    input  logic [31:0]    element_id,
    input  logic [63:0]    value,
    input  logic [3:0]     length,
    output ebml_pkg::desc_t desc
);

    logic [31:0] id_inc;
    logic [2:0]  id_cnt;
    logic [3:0]  val_bytes;
    logic [63:0] val_inc;
    logic [3:0]  needed;
    logic [3:0]  vint_len;
    logic        vint_err;
    logic        marker_err;

    assign id_inc  = element_id + 32'd1;
    assign val_inc = value + 64'd1;

    always_comb
    begin
        if (id_inc[31:8] == '0)
            id_cnt = 3'd1;
        else if (id_inc[31:15] == '0)
            id_cnt = 3'd2;
        else if (id_inc[31:22] == '0)
            id_cnt = 3'd3;
        else
            id_cnt = 3'd4;
    end

    always_comb
    begin
        val_bytes = 4'd1;
        for (int i = 1; i < 8; i++)
        begin
            if (value[8*i +: 8] != '0)
                val_bytes = 4'(i + 1);
        end
    end

    always_comb
    begin
        needed = 4'd1;
        for (int n = 1; n < 8; n++)
        begin
            if ((val_inc >> (7 * n)) != '0)
                needed = 4'(n + 1);
        end
    end

    assign vint_len   = (length == '0) ? needed : length;
    assign vint_err   = (value >= ebml_pkg::VINT_LIMIT) ||
                        ((length != '0) && ((length > ebml_pkg::MAX_LEN) || (length < needed)));
    assign marker_err = (length == '0) || (length > ebml_pkg::MAX_LEN);

    always_comb
    begin
        desc         = '0;
        desc.id      = element_id;
        case (ebml_pkg::cmd_t'(cmd))
            ebml_pkg::CMD_UINT:
            begin
                desc.id_cnt  = id_cnt;
                desc.hdr     = ebml_pkg::UINT_HDR | {4'd0, val_bytes};
                desc.hdr_cnt = 1'b1;
                desc.val     = value;
                desc.val_cnt = val_bytes;
            end
            ebml_pkg::CMD_VINT:
            begin
                if (vint_err)
                begin
                    desc.err     = 1'b1;
                    desc.hdr     = ebml_pkg::ERR_BYTE;
                    desc.hdr_cnt = 1'b1;
                end
                else
                begin
                    desc.val     = value | (64'd1 << (7 * vint_len));
                    desc.val_cnt = vint_len;
                end
            end
            ebml_pkg::CMD_MARKER:
            begin
                desc.hdr_cnt = 1'b1;
                if (marker_err)
                begin
                    desc.err = 1'b1;
                    desc.hdr = ebml_pkg::ERR_BYTE;
                end
                else
                begin
                    desc.hdr     = 8'(ebml_pkg::MARKER_BASE >> length);
                    desc.val     = '1;
                    desc.val_cnt = length - 4'd1;
                end
            end
            default:
            begin
                desc.id_cnt = id_cnt;
            end
        endcase
        desc.total = 4'(desc.id_cnt) + 4'(desc.hdr_cnt) + desc.val_cnt;
    end

endmodule

@@ src/ebml_queue.sv @@
// ----------------------------------------------------------------------------
// ebml_queue
// Two-entry queue of byte plans between the classifier and the serializer.
// ----------------------------------------------------------------------------
module ebml_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ebml_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output ebml_pkg::desc_t head_desc
);

    ebml_pkg::desc_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

@@ src/ebml_back.sv @@
// ----------------------------------------------------------------------------
// ebml_back
// Walk the head byte plan one byte per beat into a registered output stage.
// ----------------------------------------------------------------------------
module ebml_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ebml_pkg::desc_t head_desc,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            error
);

    logic [3:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       error_reg, error_next;
    logic       advance;
    logic       is_last;
    logic [1:0] id_sel_w;
    logic [2:0] val_sel_w;
    logic [7:0] cur_byte;

    assign advance   = head_valid && (!valid_reg || out_ready);
    assign is_last   = (idx_reg == head_desc.total - 4'd1);
    assign id_sel_w  = 2'(4'(head_desc.id_cnt) - 4'd1 - idx_reg);
    assign val_sel_w = 3'(head_desc.total - 4'd1 - idx_reg);
    assign pop       = advance && is_last;

    always_comb
    begin
        if (idx_reg < 4'(head_desc.id_cnt))
            cur_byte = head_desc.id[8*id_sel_w +: 8];
        else if (idx_reg < 4'(head_desc.id_cnt) + 4'(head_desc.hdr_cnt))
            cur_byte = head_desc.hdr;
        else
            cur_byte = head_desc.val[8*val_sel_w +: 8];
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        error_next = error_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            byte_next  = cur_byte;
            last_next  = is_last;
            error_next = head_desc.err;
            idx_next   = is_last ? 4'd0 : idx_reg + 4'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        error_reg <= error_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule
